// ----- design/tis_pkg.sv -----
// shared types and constants for the text to integer scanner
// no dependencies
`default_nettype none
package tis_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 2;

  localparam logic [CFG_INDEX_W-1:0] CFG_NUMBER_BASE   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SIGNED_RESULT = 1'd1;

  localparam logic [1:0] BASE_DEC = 2'd0;
  localparam logic [1:0] BASE_OCT = 2'd1;
  localparam logic [1:0] BASE_HEX = 2'd2;

  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_EIGHT = 8'h38;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_LOW_X = 8'h78;
  localparam logic [7:0] CH_UP_X  = 8'h58;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_LOW_F = 8'h66;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_UP_F  = 8'h46;

  localparam logic [63:0] SIGNED_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] SIGNED_MIN = 64'h8000_0000_0000_0000;

  typedef enum logic [1:0] {
    RADIX_8,
    RADIX_10,
    RADIX_16
  } radix_t;

  typedef enum logic [1:0] {
    OP_SIGN,
    OP_ACC,
    OP_EMIT
  } op_t;

  typedef enum logic [1:0] {
    PH_NONE,
    PH_ZERO,
    PH_X,
    PH_DIGITS
  } phase_t;

  typedef struct packed {
    op_t        op;
    logic [3:0] digit;
    radix_t     radix;
    logic       minus;
    logic       eof;
    logic       signed_mode;
  } entry_t;

endpackage
`default_nettype wire

// ----- design/tis_char_if.sv -----
// character channel: valid/ready handshake with one character or end of input
// no dependencies
`default_nettype none
interface tis_char_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       end_of_input;

  modport source (output valid, output char_code, output end_of_input, input ready);
  modport sink (input valid, input char_code, input end_of_input, output ready);
endinterface
`default_nettype wire

// ----- design/tis_result_if.sv -----
// result channel: valid/ready handshake with one converted field
// no dependencies
`default_nettype none
interface tis_result_if;
  logic        valid;
  logic        ready;
  logic [63:0] result_value;
  logic        success;
  logic        was_negative;
  logic        saturated;
  logic        ended_by_eof;

  modport source (output valid, output result_value, output success, output was_negative,
                  output saturated, output ended_by_eof, input ready);
  modport sink (input valid, input result_value, input success, input was_negative,
                input saturated, input ended_by_eof, output ready);
endinterface
`default_nettype wire

// ----- design/tis_front.sv -----
// front end: accepts characters, tracks sign and prefix, classifies into queue entries
// depends on tis_pkg, tis_char_if
`default_nettype none
module tis_front (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [tis_pkg::CFG_DATA_W-1:0] number_base,
  input  logic                         signed_result,
  tis_char_if.sink                     chars,
  output logic                         push,
  output tis_pkg::entry_t              push_entry,
  input  logic                         queue_full
);
  import tis_pkg::*;

  logic       at_start;
  logic       at_start_next;
  phase_t     phase;
  phase_t     phase_next;
  radix_t     radix;
  logic       accept;
  logic       want_push;
  logic       is_dec;
  logic       is_hex_letter;
  logic       digit_ok;
  logic [3:0] digit_val;
  logic       is_hex;
  logic [7:0] c;

  assign c            = chars.char_code;
  assign chars.ready  = !queue_full;
  assign accept       = chars.valid && chars.ready;
  assign push         = accept && want_push;

  always_comb begin
    unique case (number_base)
      BASE_OCT: radix = RADIX_8;
      BASE_HEX: radix = RADIX_16;
      default:  radix = RADIX_10;
    endcase
  end

  assign is_hex = (radix == RADIX_16);

  always_comb begin
    is_dec        = (c >= CH_ZERO) && (c <= CH_NINE);
    is_hex_letter = ((c >= CH_LOW_A) && (c <= CH_LOW_F)) ||
                    ((c >= CH_UP_A) && (c <= CH_UP_F));
    if (is_dec) begin
      digit_val = c[3:0];
    end else begin
      digit_val = c[3:0] + 4'd9;
    end
    if (is_dec) begin
      digit_ok = (radix != RADIX_8) || (c < CH_EIGHT);
    end else begin
      digit_ok = is_hex && is_hex_letter;
    end
  end

  always_comb begin
    push_entry.op          = OP_EMIT;
    push_entry.digit       = 4'd0;
    push_entry.radix       = radix;
    push_entry.minus       = 1'b0;
    push_entry.eof         = 1'b0;
    push_entry.signed_mode = signed_result;
    want_push              = 1'b1;
    at_start_next          = at_start;
    phase_next             = phase;
    priority if (chars.end_of_input) begin
      push_entry.eof = 1'b1;
      at_start_next  = 1'b1;
      phase_next     = PH_NONE;
    end else if (((c == CH_PLUS) || (c == CH_MINUS)) && at_start) begin
      push_entry.op    = OP_SIGN;
      push_entry.minus = (c == CH_MINUS);
      at_start_next    = 1'b0;
    end else if (is_hex && (phase == PH_NONE) && (c == CH_ZERO)) begin
      push_entry.op = OP_ACC;
      at_start_next = 1'b0;
      phase_next    = PH_ZERO;
    end else if (is_hex && (phase == PH_ZERO) && ((c == CH_LOW_X) || (c == CH_UP_X))) begin
      want_push  = 1'b0;
      phase_next = PH_X;
    end else if (digit_ok) begin
      push_entry.op    = OP_ACC;
      push_entry.digit = digit_val;
      at_start_next    = 1'b0;
      phase_next       = PH_DIGITS;
    end else begin
      at_start_next = 1'b1;
      phase_next    = PH_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      at_start <= 1'b1;
      phase    <= PH_NONE;
    end else if (accept) begin
      at_start <= at_start_next;
      phase    <= phase_next;
    end
  end

endmodule
`default_nettype wire

// ----- design/tis_queue.sv -----
// short fifo of classified entries between front and back
// depends on tis_pkg
`default_nettype none
module tis_queue #(
  parameter int Depth = tis_pkg::QUEUE_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  tis_pkg::entry_t push_entry,
  output logic            full,
  output logic            head_valid,
  output tis_pkg::entry_t head,
  input  logic            pop
);
  import tis_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  entry_t            entries [Depth];
  logic [PtrW-1:0]   wptr;
  logic [PtrW-1:0]   rptr;
  logic [CntW-1:0]   count;

  assign full       = (count == CntW'(Depth));
  assign head_valid = (count != '0);
  assign head       = entries[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) begin
        wptr <= (wptr == PtrW'(Depth - 1)) ? '0 : wptr + PtrW'(1);
      end
      if (pop) begin
        rptr <= (rptr == PtrW'(Depth - 1)) ? '0 : rptr + PtrW'(1);
      end
      count <= count + CntW'(push) - CntW'(pop);
    end
  end

endmodule
`default_nettype wire

// ----- design/tis_back.sv -----
// back end: radix multiply-add with overflow, field state and registered result
// depends on tis_pkg, tis_result_if
`default_nettype none
module tis_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            head_valid,
  input  tis_pkg::entry_t head,
  output logic            pop,
  tis_result_if.source    results
);
  import tis_pkg::*;

  logic [63:0] magnitude;
  logic        overflow_seen;
  logic        minus_seen;
  logic        digit_seen;

  logic        out_valid;
  logic [63:0] out_value;
  logic        out_success;
  logic        out_negative;
  logic        out_saturated;
  logic        out_eof;

  logic        load_out;
  logic [67:0] scaled;
  logic [67:0] sum;
  logic        acc_ovf;
  logic [63:0] emit_value;
  logic        emit_sat;

  assign load_out = !out_valid || results.ready;
  assign pop      = head_valid && ((head.op != OP_EMIT) || load_out);

  always_comb begin
    unique case (head.radix)
      RADIX_8:  scaled = {1'b0, magnitude, 3'b000};
      RADIX_16: scaled = {magnitude, 4'b0000};
      RADIX_10: scaled = {1'b0, magnitude, 3'b000} + {3'b000, magnitude, 1'b0};
      default:  scaled = {4'b0000, magnitude};
    endcase
    sum     = scaled + {64'd0, head.digit};
    acc_ovf = (sum[67:64] != 4'd0);
  end

  always_comb begin
    emit_value = 64'd0;
    emit_sat   = 1'b0;
    if (digit_seen) begin
      if (head.signed_mode) begin
        if (minus_seen) begin
          if (overflow_seen || (magnitude > SIGNED_MIN)) begin
            emit_value = SIGNED_MIN;
            emit_sat   = 1'b1;
          end else begin
            emit_value = 64'd0 - magnitude;
          end
        end else begin
          if (overflow_seen || (magnitude > SIGNED_MAX)) begin
            emit_value = SIGNED_MAX;
            emit_sat   = 1'b1;
          end else begin
            emit_value = magnitude;
          end
        end
      end else begin
        if (overflow_seen) begin
          emit_value = '1;
          emit_sat   = 1'b1;
        end else begin
          emit_value = minus_seen ? (64'd0 - magnitude) : magnitude;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      magnitude     <= '0;
      overflow_seen <= 1'b0;
      minus_seen    <= 1'b0;
      digit_seen    <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (pop) begin
        unique case (head.op)
          OP_SIGN: begin
            minus_seen <= head.minus;
          end
          OP_ACC: begin
            digit_seen <= 1'b1;
            if (!overflow_seen) begin
              if (acc_ovf) begin
                overflow_seen <= 1'b1;
                magnitude     <= '1;
              end else begin
                magnitude <= sum[63:0];
              end
            end
          end
          OP_EMIT: begin
            magnitude     <= '0;
            overflow_seen <= 1'b0;
            minus_seen    <= 1'b0;
            digit_seen    <= 1'b0;
          end
          default: begin
          end
        endcase
      end
      if (load_out) begin
        out_valid <= pop && (head.op == OP_EMIT);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop && (head.op == OP_EMIT)) begin
      out_value     <= emit_value;
      out_success   <= digit_seen;
      out_negative  <= minus_seen;
      out_saturated <= emit_sat;
      out_eof       <= head.eof;
    end
  end

  assign results.valid        = out_valid;
  assign results.result_value = out_value;
  assign results.success      = out_success;
  assign results.was_negative = out_negative;
  assign results.saturated    = out_saturated;
  assign results.ended_by_eof = out_eof;

endmodule
`default_nettype wire

// ----- design/text_to_integer_scanner_core.sv -----
// result path: the closing entry is queued, then the result is registered
// throughput: one character per cycle, the radix multiply-add in the back end
//   retires one queue entry per cycle; only a stalled result stops the queue
// reset: synchronous, clears config to decimal signed and the field to its start
// depends on tis_pkg, tis_char_if, tis_result_if, tis_front, tis_queue, tis_back
`default_nettype none
module text_to_integer_scanner_core #(
  parameter int QueueDepth = tis_pkg::QUEUE_DEPTH
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [tis_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tis_pkg::CFG_DATA_W-1:0]  cfg_data,
  tis_char_if.sink                       chars,
  tis_result_if.source                   results
);
  import tis_pkg::*;

  logic [CFG_DATA_W-1:0] number_base;
  logic                  signed_result;
  logic                  push;
  entry_t                push_entry;
  logic                  queue_full;
  logic                  head_valid;
  entry_t                head;
  logic                  pop;

  always_ff @(posedge clk) begin
    if (rst) begin
      number_base   <= BASE_DEC;
      signed_result <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_NUMBER_BASE:   number_base   <= cfg_data;
        CFG_SIGNED_RESULT: signed_result <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  tis_front u_front (
    .clk           (clk),
    .rst           (rst),
    .number_base   (number_base),
    .signed_result (signed_result),
    .chars         (chars),
    .push          (push),
    .push_entry    (push_entry),
    .queue_full    (queue_full)
  );

  tis_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop)
  );

  tis_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head_valid (head_valid),
    .head       (head),
    .pop        (pop),
    .results    (results)
  );

endmodule
`default_nettype wire

// ----- design/tis_checker.sv -----
// port-level assertions for the scanner and their bind to the top level
// depends on text_to_integer_scanner_core
`default_nettype none
module tis_checker (
  input logic        clk,
  input logic        rst,
  input logic        results_valid,
  input logic        results_ready,
  input logic [63:0] result_value,
  input logic        success,
  input logic        saturated
);

  // held result stays put
  a_hold: assert property (@(posedge clk) disable iff (rst)
    results_valid && !results_ready |=> results_valid && $stable(result_value))
    else $error("result changed while stalled");

  // a field with no digit carries a clean zero
  a_no_digit: assert property (@(posedge clk) disable iff (rst)
    results_valid && !success |-> (result_value == 64'd0) && !saturated)
    else $error("failed field carries a value");

  a_sat_success: assert property (@(posedge clk) disable iff (rst)
    results_valid && saturated |-> success)
    else $error("saturation without digits");

  a_reset: assert property (@(posedge clk) rst |=> !results_valid)
    else $error("result valid after reset");

endmodule

bind text_to_integer_scanner_core tis_checker u_tis_checker (
  .clk           (clk),
  .rst           (rst),
  .results_valid (results.valid),
  .results_ready (results.ready),
  .result_value  (results.result_value),
  .success       (results.success),
  .saturated     (results.saturated)
);
`default_nettype wire
